// ===== sv/cvf_pkg.sv =====
// Shared constants, pixel and window types for the 3x3 convolution filter.
// No dependencies; every other file of the block but cvf_ram imports this package.
package cvf_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int MAX_FRAME_ROWS  = 4096;
  localparam int COL_W           = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_W           = $clog2(MAX_FRAME_ROWS);

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int WIN    = 3;
  // 9 taps of 8 bits, and 5 x 255 for the sharpen center, both fit here
  localparam int SUM_W  = 12;

  // divide by 9 as multiply by a rounded-up reciprocal; exact for sums < 2296
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((1 << RECIP_SHIFT) / 9 + 1);

  // configuration port
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int MIN_FRAME_DIM = 3;
  localparam int FW_RESET      = 128;
  localparam int FH_RESET      = 72;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_DRAIN   = 1'b1;
  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  // [2] red, [1] green, [0] blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;
  // [row][col]: row 0 oldest line, col 0 leftmost
  typedef pix_t [WIN-1:0][WIN-1:0] window_t;

endpackage

// ===== sv/cvf_in_if.sv =====
// Input pixel channel: valid/ready handshake plus pixel item payload.
// Depends on cvf_pkg for channel widths.
interface cvf_in_if;
  import cvf_pkg::*;

  logic            valid;
  logic            ready;
  logic            func;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

// ===== sv/cvf_out_if.sv =====
// Output pixel channel: valid/ready handshake plus filtered pixel payload.
// Depends on cvf_pkg for channel widths.
interface cvf_out_if;
  import cvf_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ===== sv/cvf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module cvf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/cvf_kernel.sv =====
// 3x3 kernel datapath: box blur (floor of sum / 9) or sharpen (5c - 4 nbrs, clamped).
// Depends on cvf_pkg for pixel/window types and the reciprocal constant.
module cvf_kernel (
  input  logic             mode,
  input  cvf_pkg::window_t win,
  output cvf_pkg::pix_t    px
);
  import cvf_pkg::*;

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic [SUM_W-1:0]         box_sum;
    logic [SUM_W+RECIP_W-1:0] box_prod;
    logic [CH_W-1:0]          box_val;
    logic [SUM_W-1:0]         ctr5;
    logic [SUM_W-1:0]         nbr_sum;
    logic signed [SUM_W:0]    sharp_raw;
    logic [CH_W-1:0]          sharp_val;

    always_comb begin
      box_sum = '0;
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          box_sum = box_sum + SUM_W'(win[r][c][k]);
        end
      end
    end

    assign box_prod = SUM_W'(box_sum) * RECIP_9;
    // quotient is at most 255, so the byte above the shift holds all of it
    assign box_val  = box_prod[RECIP_SHIFT +: CH_W];

    assign ctr5    = SUM_W'({win[1][1][k], 2'b00}) + SUM_W'(win[1][1][k]);
    assign nbr_sum = SUM_W'(win[0][1][k]) + SUM_W'(win[2][1][k])
                   + SUM_W'(win[1][0][k]) + SUM_W'(win[1][2][k]);
    assign sharp_raw = $signed({1'b0, ctr5}) - $signed({1'b0, nbr_sum});

    always_comb begin
      if (sharp_raw[SUM_W]) begin
        sharp_val = '0;
      end else if (|sharp_raw[SUM_W-1:CH_W]) begin
        sharp_val = '1;
      end else begin
        sharp_val = sharp_raw[CH_W-1:0];
      end
    end

    assign px[k] = (mode == MODE_SHARPEN) ? sharp_val : box_val;
  end
endmodule

// ===== sv/conv3x3_blur_sharpen_filter_unit.sv =====
// Top level of the 3x3 blur/sharpen filter: counters, line stores, window, pipeline.
// Depends on cvf_pkg, cvf_in_if, cvf_out_if, cvf_ram and cvf_kernel.
//
// Usage:
//  - pix_in carries pixel items (func = pixel) in raster order, or drain items
//    (func = drain). pix_out carries one filtered pixel per result, raster order.
//  - Output runs frame_width + 1 pixels behind the input. After the last pixel of a
//    frame, send frame_width + 1 drain items to flush the rest; the final result
//    has frame_end set. A drain item with nothing pending is taken and dropped.
//  - Border pixels pass through; inner pixels get blur or sharpen per filter_mode.
//  - Configuration (cfg_we/cfg_index/cfg_data) is written while idle. Writing the
//    width or height restarts the frame; the mode applies to the next output.
//  - Throughput: one item per cycle while pix_out is not stalled. Path: each result
//    passes the stage register, then the result register, before it is valid on
//    pix_out.
//  - The two line stores are single-write, single-read RAMs; their reads are issued
//    from the next-state counters, so they never slow the stream.
//  - If pix_out stalls, the result register holds and one more item can still be
//    taken into the stage register; pix_in.ready drops only when both are full.
//  - Reset (rst, synchronous) clears counters and pipeline valids and restores the
//    register defaults (128 x 72, blur). Line stores need no clearing pass.
module conv3x3_blur_sharpen_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cvf_pkg::CFG_DATA_W-1:0]   cfg_data,
  cvf_in_if.sink                           pix_in,
  cvf_out_if.source                        pix_out
);
  import cvf_pkg::*;

  function automatic logic [COL_W-1:0] clamp_w(input logic [FW_W-1:0] v);
    if (v < FW_W'(MIN_FRAME_DIM)) begin
      clamp_w = COL_W'(MIN_FRAME_DIM - 1);
    end else if (v > FW_W'(MAX_LINE_PIXELS)) begin
      clamp_w = COL_W'(MAX_LINE_PIXELS - 1);
    end else begin
      clamp_w = COL_W'(v - FW_W'(1));
    end
  endfunction

  function automatic logic [ROW_W-1:0] clamp_h(input logic [FH_W-1:0] v);
    if (v < FH_W'(MIN_FRAME_DIM)) begin
      clamp_h = ROW_W'(MIN_FRAME_DIM - 1);
    end else if (v > FH_W'(MAX_FRAME_ROWS)) begin
      clamp_h = ROW_W'(MAX_FRAME_ROWS - 1);
    end else begin
      clamp_h = ROW_W'(v - FH_W'(1));
    end
  endfunction

  // config registers (width/height kept as clamped value minus one)
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             mode;

  // position counters
  logic [COL_W-1:0] ic, ic_next, oc, oc_next;
  logic [ROW_W-1:0] ir, ir_next, orow, orow_next;

  // window and line-store data
  window_t          win;
  pix_t             last_mid;   // middle-line value read by the previous pixel item
  pix_t             up_rd, mid_rd, npx;
  logic [COL_W-1:0] mid_raddr;

  // handshake
  logic acc_in, out_free, s1_go, geom_write, is_pixel;

  // item decode
  logic drain_live, has_result, res_filt, res_fend;
  pix_t res_px;

  // stage register
  logic s1_valid, s1_filt, s1_fend;
  pix_t s1_px;

  // result register
  logic out_valid, out_fend;
  pix_t out_px, kern_px;

  assign out_free     = !out_valid || pix_out.ready;
  assign s1_go        = s1_valid && out_free;
  assign pix_in.ready = !s1_valid || out_free;
  assign acc_in       = pix_in.valid && pix_in.ready;
  assign is_pixel     = (pix_in.func == FUNC_PIXEL);
  assign geom_write   = cfg_we && (cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});
  assign npx          = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= clamp_w(FW_W'(FW_RESET));
      h_m1 <= clamp_h(FH_W'(FH_RESET));
      mode <= MODE_BLUR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  w_m1 <= clamp_w(cfg_data[FW_W-1:0]);
        CFG_FRAME_HEIGHT: h_m1 <= clamp_h(cfg_data[FH_W-1:0]);
        CFG_FILTER_MODE:  mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ item decode
  always_comb begin
    drain_live = (ic == '0) && (ir == '0) && !((oc == '0) && (orow == '0));
    has_result = 1'b0;
    res_filt   = 1'b0;
    res_fend   = 1'b0;
    res_px     = win[1][2];
    if (!is_pixel) begin
      // pending row h-2 holds only its last pixel, captured in last_mid
      has_result = drain_live;
      res_px     = (orow == h_m1) ? mid_rd : last_mid;
      res_fend   = (orow == h_m1) && (oc == w_m1);
    end else begin
      // nothing out during the first line and at the first pixel of line 1
      has_result = !((ir == '0) || ((ir == ROW_W'(1)) && (ic == '0)));
      res_filt   = (ir >= ROW_W'(2)) && (ic >= COL_W'(2));
      // column 0: right-edge pixel of the line before; else the center tap
      res_px     = (ic == '0) ? last_mid : win[1][2];
    end
  end

  // ---------------------------------------------------------- counter logic
  always_comb begin
    ic_next   = ic;
    ir_next   = ir;
    oc_next   = oc;
    orow_next = orow;
    if (rst || geom_write) begin
      ic_next   = '0;
      ir_next   = '0;
      oc_next   = '0;
      orow_next = '0;
    end else if (acc_in) begin
      if (!is_pixel) begin
        if (drain_live) begin
          if (oc == w_m1) begin
            oc_next   = '0;
            orow_next = (orow == h_m1) ? '0 : orow + ROW_W'(1);
          end else begin
            oc_next = oc + COL_W'(1);
          end
        end
      end else begin
        if ((ir == '0) || ((ir == ROW_W'(1)) && (ic == '0))) begin
          oc_next   = '0;
          orow_next = '0;
        end else begin
          oc_next   = ic;
          orow_next = ir - ROW_W'(1);
        end
        if (ic == w_m1) begin
          ic_next = '0;
          ir_next = (ir == h_m1) ? '0 : ir + ROW_W'(1);
        end else begin
          ic_next = ic + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic   <= '0;
      ir   <= '0;
      oc   <= '0;
      orow <= '0;
    end else begin
      ic   <= ic_next;
      ir   <= ir_next;
      oc   <= oc_next;
      orow <= orow_next;
    end
  end

  // ------------------------------------------------------------ line stores
  // Reads are issued from next-state counters so the data is ready when the
  // item arrives. During the last-row drain the middle store is read at oc.
  assign mid_raddr = ((ic_next == '0) && (ir_next == '0) && (orow_next == h_m1))
                   ? oc_next : ic_next;

  cvf_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_upper_ram (
    .clk   (clk),
    .we    (acc_in && is_pixel),
    .waddr (ic),
    .wdata (mid_rd),
    .raddr (ic_next),
    .rdata (up_rd)
  );

  cvf_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_middle_ram (
    .clk   (clk),
    .we    (acc_in && is_pixel),
    .waddr (ic),
    .wdata (npx),
    .raddr (mid_raddr),
    .rdata (mid_rd)
  );

  // ------------------------------------------------------------------ window
  always_ff @(posedge clk) begin
    if (acc_in && is_pixel) begin
      for (int r = 0; r < WIN; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= npx;
      last_mid  <= mid_rd;
    end
  end

  // ---------------------------------------------------------- stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_in) begin
      s1_valid <= has_result;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (acc_in) begin
      s1_filt <= res_filt;
      s1_px   <= res_px;
      s1_fend <= res_fend;
    end
  end

  // kernel sees the window shifted by the item now in the stage register
  cvf_kernel u_kernel (
    .mode (mode),
    .win  (win),
    .px   (kern_px)
  );

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_go) begin
      out_px   <= s1_filt ? kern_px : s1_px;
      out_fend <= s1_fend;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.red_out   = out_px[2];
  assign pix_out.green_out = out_px[1];
  assign pix_out.blue_out  = out_px[0];
  assign pix_out.frame_end = out_fend;

  // -------------------------------------------------------------- assertions
  a_counters_in_frame: assert property (@(posedge clk) disable iff (rst)
    (ic <= w_m1) && (ir <= h_m1) && (oc <= w_m1) && (orow <= h_m1))
    else $error("position counter beyond frame geometry");

  a_drain_gives_result: assert property (@(posedge clk) disable iff (rst)
    (acc_in && !is_pixel && drain_live) |=> s1_valid)
    else $error("pending drain item produced no result");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.frame_end) |-> ((oc == '0) && (orow == '0)))
    else $error("frame end emitted with outputs still pending");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for conv3x3_blur_sharpen_filter_unit.
// Needs cvf_pkg, cvf_in_if, cvf_out_if and the filter RTL; tracks pixels with its own model.
module tb;
  import cvf_pkg::*;

  // one filtered pixel as it should leave pix_out
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } filtered_pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvf_in_if  pix_in_bus ();
  cvf_out_if pix_out_bus ();

  conv3x3_blur_sharpen_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in_bus),
    .pix_out   (pix_out_bus)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pixels still owed by the block, oldest first.
  filtered_pixel_t expected_pixels[$];
  int error_count   = 0;
  int counted_items = 0;   // pixel items plus drains that release a pixel
  int in_gap_max    = 11;  // longest idle run before an input item
  int out_stall_max = 11;  // longest ready-low run before a result

  // ---------------------------------------------------------------------------
  // Filter model: own copy of line stores, 3x3 window, counters and registers.
  // Rows of the window go oldest line to newest, columns left to right.
  // ---------------------------------------------------------------------------
  pix_t upper_line  [MAX_LINE_PIXELS];
  pix_t middle_line [MAX_LINE_PIXELS];
  pix_t window_px   [3][3];
  int unsigned in_col, in_row, out_col, out_row;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  logic            mode_reg;

  function automatic int unsigned line_len();
    int unsigned w;
    w = width_reg;
    if (w < MIN_FRAME_DIM) w = MIN_FRAME_DIM;
    if (w > MAX_LINE_PIXELS) w = MAX_LINE_PIXELS;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = height_reg;
    if (h < MIN_FRAME_DIM) h = MIN_FRAME_DIM;
    if (h > MAX_FRAME_ROWS) h = MAX_FRAME_ROWS;
    return h;
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < MAX_LINE_PIXELS; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) window_px[r][c] = '0;
    restart_frame();
    width_reg  = FW_W'(FW_RESET);
    height_reg = FH_W'(FH_RESET);
    mode_reg   = MODE_BLUR;
  endfunction

  // One channel of the kernel over the current window.
  // Blur: exact floor of sum/9. Sharpen: 5*center - 4 side neighbors, clamped.
  function automatic logic [CH_W-1:0] kernel_value(int ch);
    int acc;
    acc = 0;
    if (mode_reg == MODE_SHARPEN) begin
      acc = 5 * int'(window_px[1][1][ch]) - int'(window_px[0][1][ch])
          - int'(window_px[2][1][ch]) - int'(window_px[1][0][ch])
          - int'(window_px[1][2][ch]);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
    end else begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) acc += int'(window_px[r][c][ch]);
      acc = acc / 9;
    end
    return acc[CH_W-1:0];
  endfunction

  function automatic void queue_pixel(pix_t px, logic fend);
    filtered_pixel_t e;
    e.red       = px[2];
    e.green     = px[1];
    e.blue      = px[0];
    e.frame_end = fend;
    expected_pixels.push_back(e);
  endfunction

  // Advances the model by one accepted item; returns 1 when it releases a pixel.
  function automatic bit convolve_item(logic f, pix_t npx);
    int unsigned w, h, ic, ir, oc, orow;
    pix_t prev_edge, top, mid, px;
    bit made;
    w    = line_len();
    h    = frame_rows();
    ic   = in_col % w;
    ir   = in_row % h;
    made = 1'b0;
    if (f == FUNC_DRAIN) begin
      oc   = out_col % w;
      orow = out_row % h;
      // only the tail of a fully received frame is released
      if (ic != 0 || ir != 0 || (oc == 0 && orow == 0)) return 1'b0;
      px = (orow >= h - 1) ? middle_line[oc] : upper_line[oc];
      queue_pixel(px, (orow == h - 1 && oc == w - 1));
      oc++;
      if (oc >= w) begin
        oc = 0;
        orow++;
        if (orow >= h) orow = 0;
      end
      out_col = oc;
      out_row = orow;
      return 1'b1;
    end
    prev_edge = upper_line[w - 1];
    top       = upper_line[ic];
    mid       = middle_line[ic];
    for (int r = 0; r < 3; r++) begin
      window_px[r][0] = window_px[r][1];
      window_px[r][1] = window_px[r][2];
    end
    window_px[0][2] = top;
    window_px[1][2] = mid;
    window_px[2][2] = npx;
    upper_line[ic]  = mid;
    middle_line[ic] = npx;
    if (ir == 0 || (ir == 1 && ic == 0)) begin
      // frame start: nothing out yet, undrained tail of last frame is dropped
      out_col = 0;
      out_row = 0;
    end else if (ic == 0) begin
      // right border pixel of the row above
      queue_pixel(prev_edge, 1'b0);
      out_row = ir - 1;
      out_col = 0;
      made    = 1'b1;
    end else begin
      if (ir >= 2 && ic >= 2) px = {kernel_value(2), kernel_value(1), kernel_value(0)};
      else px = window_px[1][1];
      queue_pixel(px, 1'b0);
      out_row = ir - 1;
      out_col = ic;
      made    = 1'b1;
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
      if (ir >= h) ir = 0;
    end
    in_col = ic;
    in_row = ir;
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic pix_t random_pixel();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  // Register write; the enable drops after the edge that takes the write, so
  // back-to-back writes never toggle it within one time step.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = value[FW_W-1:0];
        restart_frame();
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = value[FH_W-1:0];
        restart_frame();
      end
      CFG_FILTER_MODE: mode_reg = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one item after a random idle run; valid stays up after acceptance
  // so a following item with no gap keeps it high.
  task automatic send_item(logic f, pix_t px);
    int gap;
    bit made;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.func     <= f;
    pix_in_bus.red_in   <= px[2];
    pix_in_bus.green_in <= px[1];
    pix_in_bus.blue_in  <= px[0];
    do @(posedge clk); while (pix_in_bus.ready !== 1'b1);
    made = convolve_item(f, px);
    if (made || f == FUNC_PIXEL) counted_items++;
  endtask

  // Random pixels; with noise, stray drains fall between them (ignored mid-frame).
  task automatic send_frame(int n, bit noise);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(9, 0) == 0) send_item(FUNC_DRAIN, random_pixel());
      send_item(FUNC_PIXEL, random_pixel());
    end
  endtask

  task automatic send_drains(int n);
    for (int i = 0; i < n; i++) send_item(FUNC_DRAIN, random_pixel());
  endtask

  // Idle input and wait until all owed pixels are back, then let items still in
  // the two-stage pipe that release nothing pass through.
  task automatic wait_quiet();
    pix_in_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: random ready stalls, each result against the oldest
  // expected pixel.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int stall;
    filtered_pixel_t want;
    pix_out_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        pix_out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out_bus.ready <= 1'b1;
      do @(posedge clk); while (pix_out_bus.valid !== 1'b1);
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: red_out %0d green_out %0d blue_out %0d frame_end %0d",
               pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
               pix_out_bus.frame_end);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pix_out_bus.red_out !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, pix_out_bus.red_out);
          error_count++;
        end
        if (pix_out_bus.green_out !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, pix_out_bus.green_out);
          error_count++;
        end
        if (pix_out_bus.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, pix_out_bus.blue_out);
          error_count++;
        end
        if (pix_out_bus.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", want.frame_end,
                 pix_out_bus.frame_end);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Two 3x3 frames, one center pixel each: blur of saturated and mixed
  // channels, then sharpen clamping high on red and low on green.
  // Also drains with nothing pending: after reset, mid-frame, after the tail.
  task automatic test_directed_3x3();
    pix_t px;
    write_register(CFG_FRAME_WIDTH, 3);
    write_register(CFG_FRAME_HEIGHT, 3);
    write_register(CFG_FILTER_MODE, int'(MODE_BLUR));
    send_item(FUNC_DRAIN, 24'hFFFFFF);
    for (int i = 0; i < 9; i++) begin
      px[2] = 8'hFF;
      px[1] = 8'h00;
      px[0] = (i == 4) ? 8'hFF : 8'h00;
      send_item(FUNC_PIXEL, px);
      if (i == 5) send_item(FUNC_DRAIN, 24'h000000);
    end
    send_drains(5);    // four pending plus one with nothing left
    wait_quiet();

    // mode change applies to the next frame's center pixel
    write_register(CFG_FILTER_MODE, int'(MODE_SHARPEN));
    for (int i = 0; i < 9; i++) begin
      px[2] = (i == 4) ? 8'hFF : 8'h00;
      px[1] = (i == 4) ? 8'h00 : 8'hFF;
      px[0] = 8'(i * 31);
      send_item(FUNC_PIXEL, px);
    end
    send_drains(4);
    wait_quiet();
  endtask

  // Random geometry (including values below and above the clamp range),
  // random mode, random idling. Most phases are whole frames plus tail drains;
  // the rest abandon a frame, drop part of a tail, over-drain or switch mode
  // mid-frame.
  task automatic test_random_frames();
    int unsigned w, h;
    int split;
    int pick;
    counted_items = 0;
    while (counted_items < 350) begin
      wait_quiet();
      in_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : 11;
      out_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 11;

      pick = $urandom_range(15, 0);
      if (pick == 0)      write_register(CFG_FRAME_WIDTH, $urandom_range(2047, 0));
      else if (pick == 1) write_register(CFG_FRAME_WIDTH, $urandom_range(2, 0));
      else                write_register(CFG_FRAME_WIDTH, $urandom_range(8, 3));
      pick = $urandom_range(15, 0);
      if (pick == 0)      write_register(CFG_FRAME_HEIGHT, $urandom_range(8191, 0));
      else if (pick == 1) write_register(CFG_FRAME_HEIGHT, $urandom_range(2, 0));
      else                write_register(CFG_FRAME_HEIGHT, $urandom_range(6, 3));
      if ($urandom_range(1, 0) == 1)
        write_register(CFG_FILTER_MODE, $urandom_range(1, 0));

      w = line_len();
      h = frame_rows();
      if (w * h > 64) begin
        // big geometry: only a short start, the next phase restarts the frame
        send_frame($urandom_range(6, 1), 1'b1);
        send_drains(1);
      end else begin
        case ($urandom_range(9, 0))
          6: begin
            // partial tail, then a new frame drops the rest
            send_frame(w * h, 1'b1);
            send_drains($urandom_range(w, 0));
            send_frame(w * h, 1'b0);
            send_drains(w + 1);
          end
          7: begin
            send_frame(w * h, 1'b0);
            send_drains(w + 1 + $urandom_range(3, 1));
          end
          8: begin
            // flip the kernel part way through the frame
            split = $urandom_range(w * h - 1, 1);
            send_frame(split, 1'b0);
            wait_quiet();
            write_register(CFG_FILTER_MODE, int'(!mode_reg));
            send_frame(w * h - split, 1'b0);
            send_drains(w + 1);
          end
          9: send_frame($urandom_range(w * h - 1, 1), 1'b1);
          default: begin
            send_frame(w * h, 1'b1);
            send_drains(w + 1);
          end
        endcase
      end
    end
  endtask

  // Widest line the stores hold, back to back with no idling; the start of
  // the first line only, then a drain that finds nothing pending.
  task automatic test_widest_line();
    wait_quiet();
    in_gap_max    = 0;
    out_stall_max = 0;
    write_register(CFG_FRAME_WIDTH, MAX_LINE_PIXELS);
    write_register(CFG_FRAME_HEIGHT, 3);
    write_register(CFG_FILTER_MODE, int'(MODE_SHARPEN));
    send_frame(24, 1'b0);
    send_drains(1);
    wait_quiet();
  endtask

  // All-ones height clamps to the row limit; narrow frame, first rows only.
  task automatic test_tallest_frame();
    wait_quiet();
    in_gap_max    = 0;
    out_stall_max = 0;
    write_register(CFG_FRAME_WIDTH, 3);
    write_register(CFG_FRAME_HEIGHT, 'h1FFF);
    write_register(CFG_FILTER_MODE, int'(MODE_BLUR));
    send_frame(3 * 8, 1'b0);
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_FRAME_WIDTH;
    cfg_data            <= '0;
    pix_in_bus.valid    <= 1'b0;
    pix_in_bus.func     <= FUNC_PIXEL;
    pix_in_bus.red_in   <= '0;
    pix_in_bus.green_in <= '0;
    pix_in_bus.blue_in  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    reset_model();

    test_directed_3x3();
    test_random_frames();
    test_widest_line();
    test_tallest_frame();
    wait_quiet();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
